// File: rtl/ulc_pkg.sv
`default_nettype none

package ulc_pkg;

	// Bytes that the packet store can hold; later bytes only count towards the length.
	localparam int BUFFER_BYTES = 64;

	// Fixed positions and limits within a packet.
	localparam logic [7:0] POS_CMD      = 8'd0;
	localparam logic [7:0] POS_DATA0    = 8'd1;
	localparam logic [7:0] POS_SUM_LAST = 8'd61;
	localparam logic [7:0] POS_CHECK    = 8'd62;
	localparam logic [7:0] DLEN_KEYMAP  = 8'd62;
	localparam logic [7:0] CHUNK_COMMIT = 8'd16;
	localparam logic [7:0] VALUE_NONE   = 8'h00;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_SWITCH = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		EV_ACK_FAIL     = 3'd0,
		EV_KEYMAP_OK    = 3'd1,
		EV_LED          = 3'd2,
		EV_RESEND       = 3'd3,
		EV_LINK_LOST    = 3'd4,
		EV_LINK_UP      = 3'd5,
		EV_MODE_CHANGED = 3'd6
	} ev_t;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_CHARGING = 2'd1,
		MODE_USB      = 2'd2,
		MODE_OVERRIDE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_CODE_PING     = 3'd0,
		REG_CODE_USB      = 3'd1,
		REG_CODE_FAIL     = 3'd2,
		REG_CODE_ACK      = 3'd3,
		REG_CODE_LED      = 3'd4,
		REG_CODE_CHARGING = 3'd5,
		REG_CODE_KEYMAP   = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		CLS_PING,
		CLS_USB,
		CLS_FAIL,
		CLS_ACK,
		CLS_LED,
		CLS_CHARGING,
		CLS_KEYMAP,
		CLS_NONE
	} cls_t;

	typedef struct packed {
		logic [7:0] ping;
		logic [7:0] usb;
		logic [7:0] fail;
		logic [7:0] ack;
		logic [7:0] led;
		logic [7:0] charging;
		logic [7:0] keymap;
	} codes_t;

	// A finished packet as seen by the link logic, final byte already folded in.
	typedef struct packed {
		logic       done;
		logic [7:0] len;
		logic [7:0] cmd;
		logic [7:0] d0;
		logic [7:0] check;
		logic [7:0] sum;
	} pkt_t;

	typedef struct packed {
		logic       valid;
		ev_t        ev;
		logic [7:0] value;
		logic       commit;
		mode_t      mode;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/ulc_framer.sv
`default_nettype none

module ulc_framer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          byte_en,
	input  wire logic [7:0]    rx_byte,
	output ulc_pkg::pkt_t      pkt
);
	import ulc_pkg::*;

	logic       in_packet_q;
	logic [7:0] len_q;
	logic [7:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] cmd_q;
	logic [7:0] d0_q;
	logic [7:0] check_q;

	logic [7:0] pos_inc;
	logic [7:0] sum_d;
	logic [7:0] cmd_d;
	logic [7:0] d0_d;
	logic [7:0] check_d;
	logic       done;

	// Only the command, the first data byte and the checksum byte are ever looked at,
	// so those three positions are all that is kept of the packet.
	always_comb begin
		pos_inc = pos_q + 8'd1;
		cmd_d   = (pos_q == POS_CMD) ? rx_byte : cmd_q;
		d0_d    = (pos_q == POS_DATA0) ? rx_byte : d0_q;
		check_d = (pos_q == POS_CHECK && 32'(POS_CHECK) < BUFFER_BYTES) ? rx_byte : check_q;
		sum_d   = (pos_q >= POS_DATA0 && pos_q <= POS_SUM_LAST) ? sum_q + rx_byte : sum_q;
		done    = byte_en && in_packet_q && (pos_inc >= len_q);
	end

	assign pkt = '{done: done, len: len_q, cmd: cmd_d, d0: d0_d, check: check_d, sum: sum_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			len_q       <= 8'd0;
			pos_q       <= 8'd0;
			sum_q       <= 8'd0;
		end else if (byte_en) begin
			if (!in_packet_q) begin
				len_q       <= rx_byte;
				pos_q       <= 8'd0;
				sum_q       <= 8'd0;
				in_packet_q <= 1'b1;
			end else begin
				pos_q <= pos_inc;
				sum_q <= sum_d;
				if (pos_inc >= len_q) begin
					in_packet_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en && in_packet_q) begin
			cmd_q   <= cmd_d;
			d0_q    <= d0_d;
			check_q <= check_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ulc_link.sv
`default_nettype none

module ulc_link (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic [1:0]     kind,
	input  wire logic           rx_pin_high,
	input  ulc_pkg::pkt_t       pkt,
	input  ulc_pkg::codes_t     codes,
	output ulc_pkg::res_t       res
);
	import ulc_pkg::*;

	mode_t mode_q;
	mode_t mode_d;
	logic  ping_q;
	logic  ping_d;
	cls_t  cls;
	logic  len_ok;
	logic [7:0] dlen;

	// Earlier codes win where registers share a value.
	always_comb begin
		if (pkt.cmd == codes.ping)          cls = CLS_PING;
		else if (pkt.cmd == codes.usb)      cls = CLS_USB;
		else if (pkt.cmd == codes.fail)     cls = CLS_FAIL;
		else if (pkt.cmd == codes.ack)      cls = CLS_ACK;
		else if (pkt.cmd == codes.led)      cls = CLS_LED;
		else if (pkt.cmd == codes.charging) cls = CLS_CHARGING;
		else if (pkt.cmd == codes.keymap)   cls = CLS_KEYMAP;
		else                                cls = CLS_NONE;
	end

	always_comb begin
		dlen = pkt.len - 8'd1;
		case (cls)
			CLS_PING, CLS_USB, CLS_FAIL, CLS_ACK: len_ok = (dlen == 8'd0);
			CLS_LED, CLS_CHARGING:                len_ok = (dlen == 8'd1);
			CLS_KEYMAP:                           len_ok = (dlen == DLEN_KEYMAP);
			default:                              len_ok = 1'b0;
		endcase
	end

	always_comb begin
		mode_d     = mode_q;
		ping_d     = ping_q;
		res.valid  = 1'b0;
		res.ev     = EV_ACK_FAIL;
		res.value  = VALUE_NONE;
		res.commit = 1'b0;
		unique case (kind_t'(kind))
			KIND_BYTE: begin
				if (pkt.done) begin
					if (!len_ok) begin
						res.valid = 1'b1;
					end else begin
						case (cls)
							CLS_USB: begin
								if (mode_q != MODE_OVERRIDE) mode_d = MODE_USB;
								ping_d = 1'b1;
							end
							CLS_PING, CLS_ACK: ping_d = 1'b1;
							CLS_KEYMAP: begin
								res.valid = 1'b1;
								if (pkt.sum == pkt.check) begin
									res.ev     = EV_KEYMAP_OK;
									res.value  = pkt.d0;
									res.commit = (pkt.d0 >= CHUNK_COMMIT);
								end
							end
							CLS_LED: begin
								res.valid = 1'b1;
								res.ev    = EV_LED;
								res.value = pkt.d0;
							end
							CLS_FAIL: begin
								res.valid = 1'b1;
								res.ev    = EV_RESEND;
							end
							default: ;
						endcase
					end
				end
			end
			KIND_TICK: begin
				if (mode_q != MODE_IDLE) begin
					ping_d = 1'b0;
					if (!ping_q) begin
						mode_d    = MODE_IDLE;
						res.valid = 1'b1;
						res.ev    = EV_LINK_LOST;
					end
				end else if (rx_pin_high) begin
					mode_d    = MODE_CHARGING;
					res.valid = 1'b1;
					res.ev    = EV_LINK_UP;
				end
			end
			KIND_SWITCH: begin
				if (mode_q == MODE_USB || mode_q == MODE_OVERRIDE) begin
					mode_d    = (mode_q == MODE_USB) ? MODE_OVERRIDE : MODE_USB;
					res.valid = 1'b1;
					res.ev    = EV_MODE_CHANGED;
				end
			end
			default: ;
		endcase
		res.mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			ping_q <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			ping_q <= ping_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/uart_packet_link_controller.sv
// Each request waits in the input register; its result is registered as it moves on.
// Throughput: one request per cycle, sustained while results are taken, whatever the mix.
// The figure is set by the single input register feeding the result register.
// Reset (arst_n low, asynchronous) empties both registers, leaves the link idle, clears
// framing and the watchdog, and loads the command codes with their default values.
// There is no clearing pass: the block takes requests from the first cycle after reset.
`default_nettype none

module uart_packet_link_controller (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] rx_byte,
	input  wire logic       rx_pin_high,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      event_res,
	output logic [7:0]      event_value,
	output logic            commit_keymap,
	output logic [1:0]      link_mode
);
	import ulc_pkg::*;

	// Command codes, written by the user only while idle; the block does not enforce it.
	codes_t codes_q;

	// Input register: holds one request while the framing and link logic work on it.
	logic       v_s1;
	logic [1:0] kind_s1;
	logic [7:0] byte_s1;
	logic       pin_s1;

	// Result register: the skid between the working logic and the output channel.
	logic       res_valid_q;
	res_t       res_q;

	logic       adv;
	logic       byte_en;
	pkt_t       pkt;
	res_t       res;

	// The staged request moves on once the result register is free or being emptied.
	// While a result waits unclaimed, a staged request is held and the input is refused.
	assign adv      = v_s1 && (!res_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign byte_en  = adv && (kind_t'(kind_s1) == KIND_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '{ping: 8'd0, usb: 8'd1, fail: 8'd2, ack: 8'd3,
			             led: 8'd4, charging: 8'd5, keymap: 8'd6};
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_CODE_PING:     codes_q.ping     <= cfg_data;
				REG_CODE_USB:      codes_q.usb      <= cfg_data;
				REG_CODE_FAIL:     codes_q.fail     <= cfg_data;
				REG_CODE_ACK:      codes_q.ack      <= cfg_data;
				REG_CODE_LED:      codes_q.led      <= cfg_data;
				REG_CODE_CHARGING: codes_q.charging <= cfg_data;
				REG_CODE_KEYMAP:   codes_q.keymap   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			byte_s1 <= rx_byte;
			pin_s1  <= rx_pin_high;
		end
	end

	ulc_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (byte_en),
		.rx_byte (byte_s1),
		.pkt     (pkt)
	);

	ulc_link u_link (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.kind        (kind_s1),
		.rx_pin_high (pin_s1),
		.pkt         (pkt),
		.codes       (codes_q),
		.res         (res)
	);

	// A request that causes no result simply empties the slot when it moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= res.valid;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			res_q <= res;
		end
	end

	assign out_valid     = res_valid_q;
	assign event_res     = res_q.ev;
	assign event_value   = res_q.value;
	assign commit_keymap = res_q.commit;
	assign link_mode     = res_q.mode;

	// A staged request with an unchanged result slot holding a waiting result must stay put.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && res_valid_q && !out_ready |=> v_s1 && $stable(byte_s1) && $stable(kind_s1))
		else $error("staged request lost during output stall");

	// An empty input register always takes a new request.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input refused with empty stage");

	a_commit_keymap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && commit_keymap |-> event_res == EV_KEYMAP_OK && event_value >= CHUNK_COMMIT)
		else $error("commit flag on a result that is not a committing chunk");

	a_lost_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_LINK_LOST |-> link_mode == MODE_IDLE)
		else $error("link lost reported with link not idle");

	a_up_charging: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_LINK_UP |-> link_mode == MODE_CHARGING)
		else $error("link up reported outside charging mode");

endmodule

`default_nettype wire

// File: tb/uart_packet_link_controller_tb.sv
module uart_packet_link_controller_tb;
	import ulc_pkg::*;

	// Cycles in a row without any request, result or register write before the run is abandoned.
	// The slowest correct stretch is a full receiver stall plus a full sender gap plus
	// the pause before a register write.
	localparam int unsigned WATCHDOG_LIMIT = 400;
	// Pause after the last result before the block is taken to be idle.
	// Requests that cause no result may still be in flight.
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned MAX_WAIT       = 11;
	localparam int unsigned PHASE_REQUESTS = 60;
	localparam int unsigned BUF_AW         = $clog2(BUFFER_BYTES);
	localparam logic [1:0]  KIND_UNUSED    = 2'd3;
	localparam logic [7:0]  KEYMAP_LENGTH  = 8'd63;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       pin;
	} request_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [2:0] cfg_index   = '0;
	logic [7:0] cfg_data    = '0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [1:0] kind        = '0;
	logic [7:0] rx_byte     = '0;
	logic       rx_pin_high = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [2:0] event_res;
	logic [7:0] event_value;
	logic       commit_keymap;
	logic [1:0] link_mode;

	uart_packet_link_controller u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.rx_byte       (rx_byte),
		.rx_pin_high   (rx_pin_high),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_res     (event_res),
		.event_value   (event_value),
		.commit_keymap (commit_keymap),
		.link_mode     (link_mode)
	);

	// The testbench's own view of the link: command codes, packet framing and link state.
	// It is only ever touched by the driver, except for the codes, which change while idle.
	codes_t     cfg_codes;
	logic       framing;
	logic [7:0] frame_len;
	logic [7:0] frame_pos;
	logic [7:0] chunk_sum;
	logic [7:0] frame_bytes [BUFFER_BYTES];
	mode_t      link_state;
	logic       ping_flag;

	request_t    request_queue[$];
	res_t        expected_events[$];
	int unsigned queued_count   = 0;
	int unsigned sent_count     = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles   = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// The first matching code wins, in register order, so colliding codes resolve as the
	// block does.
	function automatic cls_t classify_command(logic [7:0] cmd);
		if (cmd == cfg_codes.ping)     return CLS_PING;
		if (cmd == cfg_codes.usb)      return CLS_USB;
		if (cmd == cfg_codes.fail)     return CLS_FAIL;
		if (cmd == cfg_codes.ack)      return CLS_ACK;
		if (cmd == cfg_codes.led)      return CLS_LED;
		if (cmd == cfg_codes.charging) return CLS_CHARGING;
		if (cmd == cfg_codes.keymap)   return CLS_KEYMAP;
		return CLS_NONE;
	endfunction

	// A packet has just completed. The data length is checked against the command first;
	// only a packet of the right length has any further effect.
	function automatic res_t judge_packet();
		res_t       r;
		cls_t       cls;
		logic [7:0] dlen;
		logic       len_ok;
		r = '0;
		r.value = VALUE_NONE;
		cls = classify_command(frame_bytes[POS_CMD[BUF_AW-1:0]]);
		dlen = frame_len - 8'd1;
		case (cls)
			CLS_PING, CLS_USB, CLS_FAIL, CLS_ACK: len_ok = (dlen == 8'd0);
			CLS_LED, CLS_CHARGING:                len_ok = (dlen == 8'd1);
			CLS_KEYMAP:                           len_ok = (dlen == DLEN_KEYMAP);
			default:                              len_ok = 1'b0;
		endcase
		if (!len_ok) begin
			r.valid = 1'b1;
			r.ev = EV_ACK_FAIL;
		end else begin
			case (cls)
				CLS_USB: begin
					// The radio override survives a usb status packet.
					if (link_state != MODE_OVERRIDE) link_state = MODE_USB;
					ping_flag = 1'b1;
				end
				CLS_PING, CLS_ACK: begin
					ping_flag = 1'b1;
				end
				CLS_KEYMAP: begin
					r.valid = 1'b1;
					if (chunk_sum != frame_bytes[POS_CHECK[BUF_AW-1:0]]) begin
						r.ev = EV_ACK_FAIL;
					end else begin
						r.ev = EV_KEYMAP_OK;
						r.value = frame_bytes[POS_DATA0[BUF_AW-1:0]];
						r.commit = (frame_bytes[POS_DATA0[BUF_AW-1:0]] >= CHUNK_COMMIT);
					end
				end
				CLS_LED: begin
					r.valid = 1'b1;
					r.ev = EV_LED;
					r.value = frame_bytes[POS_DATA0[BUF_AW-1:0]];
				end
				CLS_FAIL: begin
					r.valid = 1'b1;
					r.ev = EV_RESEND;
				end
				default: begin
				end
			endcase
		end
		r.mode = link_state;
		return r;
	endfunction

	// Advances the link by one accepted request and returns the event it causes, if any.
	function automatic res_t predict_link_event(logic [1:0] k, logic [7:0] b, logic pin);
		res_t r;
		r = '0;
		case (k)
			KIND_BYTE: begin
				if (!framing) begin
					frame_len = b;
					frame_pos = '0;
					chunk_sum = '0;
					framing = 1'b1;
				end else begin
					// Bytes beyond the store still count towards the length.
					if (frame_pos < BUFFER_BYTES) frame_bytes[frame_pos[BUF_AW-1:0]] = b;
					if (frame_pos >= POS_DATA0 && frame_pos <= POS_SUM_LAST) chunk_sum = chunk_sum + b;
					frame_pos = frame_pos + 8'd1;
					if (frame_pos >= frame_len) begin
						framing = 1'b0;
						r = judge_packet();
					end
				end
			end
			KIND_TICK: begin
				if (link_state != MODE_IDLE) begin
					if (!ping_flag) begin
						link_state = MODE_IDLE;
						r.valid = 1'b1;
						r.ev = EV_LINK_LOST;
					end
					ping_flag = 1'b0;
				end else if (pin) begin
					link_state = MODE_CHARGING;
					r.valid = 1'b1;
					r.ev = EV_LINK_UP;
				end
			end
			KIND_SWITCH: begin
				if (link_state == MODE_USB) begin
					link_state = MODE_OVERRIDE;
					r.valid = 1'b1;
					r.ev = EV_MODE_CHANGED;
				end else if (link_state == MODE_OVERRIDE) begin
					link_state = MODE_USB;
					r.valid = 1'b1;
					r.ev = EV_MODE_CHANGED;
				end
			end
			default: begin
			end
		endcase
		r.mode = link_state;
		return r;
	endfunction

	// Driver. A request is held until accepted; after each one the sender waits a drawn number
	// of cycles, except during steady stretches, which come and go at random.
	always @(posedge clk or negedge arst_n) begin
		res_t        ev;
		request_t    nxt;
		int unsigned send_wait;
		logic        send_steady;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait = 0;
			send_steady = 1'b0;
			framing = 1'b0;
			frame_len = '0;
			frame_pos = '0;
			chunk_sum = '0;
			link_state = MODE_IDLE;
			ping_flag = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				ev = predict_link_event(kind, rx_byte, rx_pin_high);
				if (ev.valid) expected_events.push_back(ev);
				sent_count++;
				if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
			end
			if (!in_valid || in_ready) begin
				if (send_wait != 0) begin
					in_valid <= 1'b0;
					send_wait--;
				end else if (request_queue.size() != 0) begin
					nxt = request_queue.pop_front();
					in_valid <= 1'b1;
					kind <= nxt.kind;
					rx_byte <= nxt.data;
					rx_pin_high <= nxt.pin;
					send_wait = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every result is matched against the oldest outstanding event, field by field.
	// The receiver stalls for a drawn number of cycles after each result it takes.
	always @(posedge clk or negedge arst_n) begin
		res_t        want;
		int unsigned recv_wait;
		logic        recv_steady;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
			recv_steady = 1'b0;
		end else begin
			if (recv_wait != 0) recv_wait--;
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					$error("result with no event outstanding: event_res %0d", event_res);
					mismatch_count++;
				end else begin
					want = expected_events.pop_front();
					if (event_res !== want.ev) begin
						$error("event_res: expected %0d, got %0d", want.ev, event_res);
						mismatch_count++;
					end
					if (event_value !== want.value) begin
						$error("event_value: expected %0d, got %0d", want.value, event_value);
						mismatch_count++;
					end
					if (commit_keymap !== want.commit) begin
						$error("commit_keymap: expected %0d, got %0d", want.commit, commit_keymap);
						mismatch_count++;
					end
					if (link_mode !== want.mode) begin
						$error("link_mode: expected %0d, got %0d", want.mode, link_mode);
						mismatch_count++;
					end
				end
				if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
				recv_wait = recv_steady ? 0 : $urandom_range(0, MAX_WAIT);
			end
			out_ready <= (recv_wait == 0);
		end
	end

	// Watchdog: a run that stops moving is a failure.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_request(logic [1:0] k, logic [7:0] b, logic pin);
		request_t r;
		r.kind = k;
		r.data = b;
		r.pin = pin;
		request_queue.push_back(r);
		queued_count++;
	endtask

	// Unused fields carry random values so that the block is seen to ignore them.
	task automatic push_byte(logic [7:0] b);
		push_request(KIND_BYTE, b, 1'($urandom_range(0, 1)));
	endtask

	task automatic push_tick(logic pin);
		push_request(KIND_TICK, 8'($urandom_range(0, 255)), pin);
	endtask

	task automatic push_switch();
		push_request(KIND_SWITCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// A byte inside a packet; now and then a tick or a mode switch slips in ahead of it,
	// which must leave the framing alone.
	task automatic push_inner(logic [7:0] b, bit mix);
		if (mix && $urandom_range(0, 39) == 0) begin
			if ($urandom_range(0, 1) == 0) push_tick(1'($urandom_range(0, 1)));
			else push_switch();
		end
		push_byte(b);
	endtask

	task automatic push_short(logic [7:0] cmd, int unsigned ndata, bit mix);
		push_byte(8'(ndata + 1));
		push_inner(cmd, mix);
		repeat (ndata) push_inner(8'($urandom_range(0, 255)), mix);
	endtask

	// A keymap chunk: command, chunk id, sixty more data bytes, then the checksum of the
	// chunk id and those sixty bytes. A bad chunk gets a checksum that is off by a non-zero
	// amount.
	task automatic push_keymap(logic [7:0] chunk, bit good);
		logic [7:0] sum;
		logic [7:0] b;
		push_byte(KEYMAP_LENGTH);
		push_inner(cfg_codes.keymap, 1'b1);
		push_inner(chunk, 1'b1);
		sum = chunk;
		repeat (60) begin
			b = 8'($urandom_range(0, 255));
			sum = sum + b;
			push_inner(b, 1'b1);
		end
		if (!good) sum = sum + 8'($urandom_range(1, 255));
		push_inner(sum, 1'b1);
	endtask

	// A packet longer than the store: the tail is counted but not kept.
	task automatic push_overlong(logic [7:0] len);
		push_byte(len);
		repeat (len) push_inner(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Mostly well-formed packets under the current codes, mixed with ticks and mode switches
	// so that the link keeps coming up and dropping; the rest is malformed traffic.
	task automatic push_random_segment();
		int unsigned pick;
		logic [7:0]  cmd;
		pick = $urandom_range(0, 199);
		case ($urandom_range(0, 6))
			0:       cmd = cfg_codes.ping;
			1:       cmd = cfg_codes.usb;
			2:       cmd = cfg_codes.fail;
			3:       cmd = cfg_codes.ack;
			4:       cmd = cfg_codes.led;
			5:       cmd = cfg_codes.charging;
			default: cmd = cfg_codes.keymap;
		endcase
		if (pick == 0) begin
			push_overlong(8'($urandom_range(65, 100)));
		end else if (pick < 3) begin
			push_request(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end else if (pick < 30) begin
			push_tick(1'($urandom_range(0, 1)));
		end else if (pick < 46) begin
			push_switch();
		end else if (pick < 70) begin
			push_short(cfg_codes.ping, 0, 1'b1);
		end else if (pick < 86) begin
			push_short(cfg_codes.usb, 0, 1'b1);
		end else if (pick < 96) begin
			push_short(cfg_codes.ack, 0, 1'b1);
		end else if (pick < 106) begin
			push_short(cfg_codes.fail, 0, 1'b1);
		end else if (pick < 124) begin
			push_short(cfg_codes.led, 1, 1'b1);
		end else if (pick < 134) begin
			push_short(cfg_codes.charging, 1, 1'b1);
		end else if (pick < 144) begin
			push_keymap(8'($urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 255)),
				$urandom_range(0, 4) != 0);
		end else if (pick < 166) begin
			// A known command with a length that is likely wrong for it.
			push_short(cmd, $urandom_range(0, 3), 1'b1);
		end else if (pick < 176) begin
			// A zero length byte: the next byte alone closes the packet.
			push_byte(8'd0);
			push_inner(cmd, 1'b1);
		end else begin
			push_short(8'($urandom_range(0, 255)), $urandom_range(0, 2), 1'b1);
		end
	endtask

	task automatic random_phase(int unsigned n);
		int unsigned stop;
		stop = queued_count + n;
		while (queued_count < stop) push_random_segment();
	endtask

	// Waits until every request has been taken and every event has arrived,
	// then lets requests that cause no event clear the block.
	task automatic drain();
		while (sent_count != queued_count || expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_code(cfg_idx_t idx, logic [7:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	// Only called while the block is idle, so the local copy may change at once.
	task automatic apply_codes(codes_t c);
		write_code(REG_CODE_PING, c.ping);
		write_code(REG_CODE_USB, c.usb);
		write_code(REG_CODE_FAIL, c.fail);
		write_code(REG_CODE_ACK, c.ack);
		write_code(REG_CODE_LED, c.led);
		write_code(REG_CODE_CHARGING, c.charging);
		write_code(REG_CODE_KEYMAP, c.keymap);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_codes = c;
	endtask

	initial begin
		codes_t c;
		// Codes after reset, in register order from ping to keymap.
		cfg_codes = {8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset codes. The link starts idle with no ping seen.
		push_tick(1'b0);                     // Idle with the pin low: nothing happens.
		push_switch();                       // A switch while idle is ignored.
		push_tick(1'b1);                     // The pin high brings the link up charging.
		push_switch();                       // A switch while charging is ignored.
		push_short(cfg_codes.ping, 0, 1'b0); // Arms the watchdog.
		push_tick(1'b0);                     // Ping seen: the link stays up.
		push_tick(1'b1);                     // No ping since the last tick: link lost.
		push_tick(1'b1);                     // Back up again.
		push_short(cfg_codes.usb, 0, 1'b0);  // Moves to usb mode.
		push_switch();                       // usb to radio override.
		push_short(cfg_codes.usb, 0, 1'b0);  // Override is kept.
		push_switch();                       // Back to usb.
		push_byte(8'd2);                     // LED packet carrying the top value.
		push_byte(cfg_codes.led);
		push_byte(8'hFF);
		push_short(cfg_codes.fail, 0, 1'b0); // Resend request.
		push_short(cfg_codes.ack, 0, 1'b0);
		push_short(cfg_codes.charging, 1, 1'b0);
		push_short(8'hFF, 0, 1'b0);          // Unknown command.
		push_byte(8'd0);                     // Zero length, so the data length wraps.
		push_byte(cfg_codes.ping);
		push_short(cfg_codes.ping, 1, 1'b0); // Ping with a data byte it should not have.
		push_request(KIND_UNUSED, 8'h00, 1'b1);
		push_tick(1'b0);
		drain();

		// Keymap chunks either side of the commit boundary, a corrupt one, and the longest
		// packet the length byte allows.
		push_keymap(CHUNK_COMMIT, 1'b1);
		push_keymap(CHUNK_COMMIT - 8'd1, 1'b1);
		push_keymap(8'($urandom_range(0, 255)), 1'b0);
		push_overlong(8'd255);
		random_phase(PHASE_REQUESTS);
		drain();

		// Extreme code values, including both ends of the byte range.
		c = {8'hFF, 8'h00, 8'h80, 8'h7F, 8'hFE, 8'h01, 8'h5A};
		apply_codes(c);
		random_phase(PHASE_REQUESTS);
		drain();

		// Codes squeezed into a narrow range, so that several commands share a code.
		for (int i = 0; i < 7; i++) c[8 * i +: 8] = 8'($urandom_range(0, 3));
		apply_codes(c);
		random_phase(PHASE_REQUESTS);
		drain();

		// Codes anywhere in the byte range.
		for (int i = 0; i < 7; i++) c[8 * i +: 8] = 8'($urandom_range(0, 255));
		apply_codes(c);
		random_phase(PHASE_REQUESTS);
		drain();

		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
